// ===== hdl/hre_pkg.sv =====
// shared types, codes and helpers for the hex record encoder
package hre_pkg;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_DATA  = 2'd1,
		FUNC_END   = 2'd2
	} func_t;

	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_NUL  = 8'h00;

	localparam logic [3:0] NUL_COUNT_RESET = 4'd6;

	// index of the last hex nibble: one data byte or a three byte header
	localparam logic [2:0] HEX_LAST_DATA = 3'd1;
	localparam logic [2:0] HEX_LAST_HDR  = 3'd5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one unit of work for the character sequencer
	typedef struct packed {
		logic        semi;
		logic [2:0]  hex_last;
		logic [23:0] hex_word;
		logic        line_end;
		logic [15:0] sum;
	} job_t;

	typedef enum logic [2:0] {
		ST_BEGIN,
		ST_HEX,
		ST_SUM,
		ST_CR,
		ST_LF,
		ST_NUL
	} bk_state_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'h0, nib};
		end else begin
			c = 8'h37 + {4'h0, nib};
		end
		return c;
	endfunction

endpackage

// ===== hdl/hre_if.sv =====
// request channels: encoder input items and output characters
interface hre_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [4:0]  byte_count;
	logic [15:0] load_address;
	logic [7:0]  data_byte;

	modport source (output valid, func, byte_count, load_address, data_byte, input ready);
	modport sink (input valid, func, byte_count, load_address, data_byte, output ready);
endinterface

interface hre_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink (input valid, out_char, last_char, output ready);
endinterface

// ===== hdl/hre_front.sv =====
// front end: takes requests, tracks record state, queues character jobs
module hre_front #(
	parameter int unsigned MAX_RECORD_BYTES = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	hre_in_if.sink         in_ch,
	input  logic           q_full,
	output logic           push,
	output hre_pkg::job_t  job
);
	import hre_pkg::*;

	logic [4:0]  remain_q, remain_d;
	logic [15:0] sum_q, sum_d;
	logic [15:0] recs_q, recs_d;
	logic [4:0]  count_eff;
	logic        accept;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;

	always_comb begin
		if ({3'b000, in_ch.byte_count} > 8'(MAX_RECORD_BYTES)) begin
			count_eff = 5'(MAX_RECORD_BYTES);
		end else if (in_ch.byte_count == 5'd0) begin
			count_eff = 5'd1;
		end else begin
			count_eff = in_ch.byte_count;
		end
	end

	always_comb begin
		remain_d = remain_q;
		sum_d    = sum_q;
		recs_d   = recs_q;
		push     = 1'b0;
		job      = '0;
		if (accept) begin
			case (in_ch.func)
				FUNC_START: begin
					if (remain_q == 5'd0) begin
						recs_d   = recs_q + 16'd1;
						sum_d    = {11'd0, count_eff} + {8'd0, in_ch.load_address[15:8]}
						           + {8'd0, in_ch.load_address[7:0]};
						remain_d = count_eff;
						push     = 1'b1;
						job      = '{semi: 1'b1, hex_last: HEX_LAST_HDR,
						             hex_word: {3'b000, count_eff, in_ch.load_address},
						             line_end: 1'b0, sum: sum_d};
					end
				end
				FUNC_DATA: begin
					if (remain_q != 5'd0) begin
						sum_d    = sum_q + {8'd0, in_ch.data_byte};
						remain_d = remain_q - 5'd1;
						push     = 1'b1;
						job      = '{semi: 1'b0, hex_last: HEX_LAST_DATA,
						             hex_word: {in_ch.data_byte, 16'h0000},
						             line_end: (remain_q == 5'd1), sum: sum_d};
					end
				end
				FUNC_END: begin
					if (remain_q == 5'd0) begin
						sum_d = {8'd0, recs_q[15:8]} + {8'd0, recs_q[7:0]};
						push  = 1'b1;
						job   = '{semi: 1'b1, hex_last: HEX_LAST_HDR,
						          hex_word: {8'h00, recs_q},
						          line_end: 1'b1, sum: sum_d};
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			sum_q    <= '0;
			recs_q   <= '0;
		end else begin
			remain_q <= remain_d;
			sum_q    <= sum_d;
			recs_q   <= recs_d;
		end
	end

endmodule

// ===== hdl/hre_queue.sv =====
// small job queue between front end and character sequencer
module hre_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hre_pkg::job_t  push_job,
	input  logic           pop,
	output hre_pkg::job_t  head,
	output logic           full,
	output logic           empty
);
	import hre_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/hre_back.sv =====
// back end: walks the head job one character a cycle into the output register while the output is not stalled
module hre_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  hre_pkg::job_t       head,
	input  logic [3:0]          nul_count,
	output logic                pop,
	output hre_pkg::bk_state_t  state,
	hre_out_if.source           out_ch
);
	import hre_pkg::*;

	bk_state_t  state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic       fire;
	logic       done;
	logic [7:0] ch;
	logic [3:0] hex_nib;
	logic [3:0] sum_nib;

	assign fire  = !q_empty && (!out_valid_q || out_ch.ready);
	assign pop   = fire && done;
	assign state = state_q;

	assign hex_nib = head.hex_word[5'd20 - {cnt_q[2:0], 2'b00} +: 4];
	assign sum_nib = head.sum[4'd12 - {cnt_q[1:0], 2'b00} +: 4];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		done    = 1'b0;
		ch      = CHAR_NUL;
		case (state_q)
			ST_BEGIN: begin
				if (head.semi) begin
					ch      = CHAR_SEMI;
					state_d = ST_HEX;
					cnt_d   = 4'd0;
				end else begin
					// data job: first nibble now, second one follows
					ch      = hex_char(hex_nib);
					state_d = ST_HEX;
					cnt_d   = 4'd1;
				end
			end
			ST_HEX: begin
				ch    = hex_char(hex_nib);
				cnt_d = cnt_q + 4'd1;
				if (cnt_q[2:0] == head.hex_last) begin
					cnt_d = 4'd0;
					if (head.line_end) begin
						state_d = ST_SUM;
					end else begin
						done = 1'b1;
					end
				end
			end
			ST_SUM: begin
				ch    = hex_char(sum_nib);
				cnt_d = cnt_q + 4'd1;
				if (cnt_q[1:0] == 2'd3) begin
					cnt_d   = 4'd0;
					state_d = ST_CR;
				end
			end
			ST_CR: begin
				ch      = CHAR_CR;
				state_d = ST_LF;
			end
			ST_LF: begin
				ch    = CHAR_LF;
				cnt_d = 4'd0;
				if (nul_count == 4'd0) begin
					done = 1'b1;
				end else begin
					state_d = ST_NUL;
				end
			end
			ST_NUL: begin
				ch    = CHAR_NUL;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q + 4'd1 == nul_count) begin
					done = 1'b1;
				end
			end
			default: begin
				state_d = ST_BEGIN;
			end
		endcase
		if (done) begin
			state_d = ST_BEGIN;
			cnt_d   = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BEGIN;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				state_q     <= state_d;
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_char_q <= ch;
			out_last_q <= done;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_char  = out_char_q;
	assign out_ch.last_char = out_last_q;

endmodule

// ===== hdl/hex_record_encoder_core.sv =====
// top level: hex record encoder with front end, job queue and character sequencer
// Turns start, data and end requests into MOS-style hex record text, one character per
// cycle on the output channel while it is not stalled. The front end takes one input
// request per cycle while its four-entry job queue has room; the sequencer emits from
// the queue head: two hex characters per data byte, a semicolon and six hex characters
// for a start or end record, and after the last data byte or an end record four checksum
// characters, CR, LF and the trailer NULs. The single output port sets the sustained rate.
// Requests that do not fit the record state (data with no open record, start or end while
// one is open, function code 3) are taken and produce nothing. cfg_we writes the 4-bit
// trailer NUL count (reset 6), to be changed only while the encoder is idle.
module hex_record_encoder_core #(
	parameter int unsigned MAX_RECORD_BYTES = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	hre_in_if.sink     in_ch,
	hre_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata
);
	import hre_pkg::*;

	logic       trailer_nul_q;
	logic [3:0] nul_count_q;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	job_t       push_job;
	job_t       head;
	bk_state_t  bk_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nul_count_q <= NUL_COUNT_RESET;
		end else if (cfg_we) begin
			nul_count_q <= cfg_wdata;
		end
	end

	// flag that goes high once reset is released and stays high; gates the last check below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trailer_nul_q <= 1'b0;
		end else begin
			trailer_nul_q <= 1'b1;
		end
	end

	hre_front #(
		.MAX_RECORD_BYTES(MAX_RECORD_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	hre_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	hre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.nul_count (nul_count_q),
		.pop       (pop),
		.state     (bk_state),
		.out_ch    (out_ch)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job popped from an empty queue");

	a_idle_at_begin: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> bk_state == ST_BEGIN)
		else $error("sequencer mid-job with no job queued");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(trailer_nul_q && pop) |=> (out_ch.valid && out_ch.last_char))
		else $error("job retired without a last character");

endmodule
